### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Clocked property checks, one reset-gated and one not; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CAS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAS_ASSERT(lbl, clk, rstn, prop, msg)
`define CAS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/cas_pkg.sv
`timescale 1ns / 1ps
// Package for the centroid accumulate and score block.
// Types, opcodes, register indexes and defaults; no dependencies.
package cas_pkg;

  localparam int MAX_DIMS_DEF = 64;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SCORE  = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_RESET  = 3'd4;

  localparam logic [1:0] REG_DIMS       = 2'd0;
  localparam logic [1:0] REG_PRIOR_STR  = 2'd1;
  localparam logic [1:0] REG_PRIOR_MEAN = 2'd2;

  localparam logic       KIND_SCORE  = 1'b0;
  localparam logic       KIND_UPDATE = 1'b1;

  localparam logic [6:0]  DIMS_RST  = 7'd64;
  localparam logic [15:0] PRIOR_RST = 16'd256;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         dim_index;
    logic signed [31:0] value;
    logic [15:0]        weight;
    logic               last_element;
  } cas_in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [63:0] score;
    logic               saturated;
  } cas_out_t;

  typedef struct packed {
    logic re;
    logic mean_we;
    logic sum_we;
    logic sum_clr;
  } cas_mem_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_UCHK, ST_UNUM, ST_UDIV, ST_OUT
  } cas_state_t;

endpackage

### hw/rtl/centroid_accumulate_and_score_top.sv
`timescale 1ns / 1ps
// Load, add, score and reset items go through read, multiply and write back;
// a score item that ends a vector then waits in ST_OUT for the result register.
// Update then runs check, numerator and the 64-step divider per dimension in use
// (straight to the result with a zero denominator or no dimension in use).
// Synchronous active-low reset clears all stores, counters and the sticky flag.
`include "assert_macros.svh"
module centroid_accumulate_and_score_top import cas_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  cas_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cas_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  localparam int STORE_DEPTH = (MAX_DIMS < 64) ? MAX_DIMS : 64;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW          = $clog2(STORE_DEPTH + 1);

  cas_state_t         state_r, state_nxt;
  cas_in_t            item_r;
  logic [6:0]         dims_r;
  logic [15:0]        pstr_r;
  logic signed [31:0] pmean_r;
  logic [39:0]        tw_r, tw_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic               sticky_r, sticky_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [63:0] pterm_r;
  logic [40:0]        den_r;
  logic [CW-1:0]      i_r, i_nxt;
  logic               neg_r;
  logic               out_valid_r;
  cas_out_t           out_r;
  logic               out_load;

  cas_mem_ctl_t       ctl;
  logic [AW-1:0]      addr;
  logic signed [31:0] mean_wd, mean_rd;
  logic signed [63:0] sum_wd, sum_rd;

  logic               div_start, div_busy, div_done;
  logic [63:0]        div_dividend, div_quot;

  logic [31:0]        act32, walk32;
  logic               ok;
  logic signed [32:0] dist_d;
  logic [31:0]        dist_m;
  logic signed [64:0] sum_ext;
  logic signed [64:0] num_ext;
  logic signed [63:0] num;
  logic               num_sat;
  logic [40:0]        tw_sum;
  logic [63:0]        qsat;
  logic               qsat_f;

  assign act32  = (32'(dims_r) > 32'(MAX_DIMS)) ? 32'(MAX_DIMS) : 32'(dims_r);
  assign walk32 = (act32 > 32'(STORE_DEPTH)) ? 32'(STORE_DEPTH) : act32;
  assign ok     = 32'(item_r.dim_index) < act32;

  cas_mem #(.DEPTH(STORE_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .addr(addr),
    .mean_wd(mean_wd), .sum_wd(sum_wd), .mean_rd(mean_rd), .sum_rd(sum_rd)
  );

  cas_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(den_r), .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  always_comb begin
    dist_d  = 33'(mean_rd) - 33'(item_r.value);
    dist_m  = dist_d[32] ? 32'(-dist_d) : dist_d[31:0];
    sum_ext = 65'(sum_rd) + 65'(prod_r);
    num_ext = 65'(sum_rd) + 65'(pterm_r);
    num_sat = num_ext[64] != num_ext[63];
    num     = num_sat ? (num_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : num_ext[63:0];
    tw_sum  = 41'(tw_r) + 41'(item_r.weight);
    div_dividend = num[63] ? (64'd0 - num) : num;
    qsat_f  = neg_r ? (div_quot > 64'h8000_0000) : (div_quot > 64'h7FFF_FFFF);
    qsat    = qsat_f ? (neg_r ? 64'h8000_0000 : 64'h7FFF_FFFF) : div_quot;
  end

  always_comb begin
    state_nxt  = state_r;
    tw_nxt     = tw_r;
    acc_nxt    = acc_r;
    sticky_nxt = sticky_r;
    prod_nxt   = prod_r;
    i_nxt      = i_r;
    ctl        = '0;
    addr       = AW'(item_r.dim_index);
    mean_wd    = item_r.value;
    sum_wd     = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        addr = AW'(in_data.dim_index);
        if (in_valid) begin
          ctl.re    = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (item_r.opcode == OP_ADD) begin
          prod_nxt = 64'($signed({1'b0, item_r.weight}) * item_r.value);
        end else begin
          prod_nxt = $signed(64'(dist_m) * 64'(dist_m));
        end
        i_nxt     = '0;
        state_nxt = (item_r.opcode == OP_UPDATE) ? ST_UCHK : ST_ACC;
      end
      ST_ACC: begin
        state_nxt = ST_IDLE;
        case (item_r.opcode)
          OP_LOAD: begin
            if (ok) begin
              ctl.mean_we = 1'b1;
              ctl.sum_we  = 1'b1;
            end
            if (item_r.last_element) begin
              tw_nxt = '0;
            end
          end
          OP_ADD: begin
            if (ok) begin
              ctl.sum_we = 1'b1;
              if (sum_ext[64] != sum_ext[63]) begin
                sum_wd     = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                sticky_nxt = 1'b1;
              end else begin
                sum_wd = sum_ext[63:0];
              end
            end
            if (item_r.last_element) begin
              if (tw_sum[40]) begin
                tw_nxt     = '1;
                sticky_nxt = 1'b1;
              end else begin
                tw_nxt = tw_sum[39:0];
              end
            end
          end
          OP_SCORE: begin
            if (ok) begin
              if (64'(prod_r) > (64'h8000_0000_0000_0000 - acc_r)) begin
                acc_nxt    = 64'h8000_0000_0000_0000;
                sticky_nxt = 1'b1;
              end else begin
                acc_nxt = acc_r + 64'(prod_r);
              end
            end
            if (item_r.last_element) begin
              state_nxt = ST_OUT;
            end
          end
          OP_RESET: begin
            ctl.sum_clr = 1'b1;
            tw_nxt      = '0;
            sticky_nxt  = 1'b0;
          end
          default: begin
          end
        endcase
      end
      ST_UCHK: begin
        addr = AW'(i_r);
        if (den_r == '0 || walk32 == '0) begin
          state_nxt = ST_OUT;
        end else begin
          ctl.re    = 1'b1;
          state_nxt = ST_UNUM;
        end
      end
      ST_UNUM: begin
        addr      = AW'(i_r);
        div_start = 1'b1;
        if (num_sat) begin
          sticky_nxt = 1'b1;
        end
        state_nxt = ST_UDIV;
      end
      ST_UDIV: begin
        addr = AW'(i_r);
        if (div_done) begin
          ctl.mean_we = 1'b1;
          mean_wd     = neg_r ? 32'(64'd0 - qsat) : qsat[31:0];
          if (qsat_f) begin
            sticky_nxt = 1'b1;
          end
          i_nxt     = i_r + CW'(1);
          state_nxt = (32'(i_r) + 32'd1 < walk32) ? ST_UCHK : ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (item_r.opcode == OP_SCORE) begin
            acc_nxt = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dims_r      <= DIMS_RST;
      pstr_r      <= PRIOR_RST;
      pmean_r     <= '0;
      tw_r        <= '0;
      acc_r       <= '0;
      sticky_r    <= 1'b0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tw_r     <= tw_nxt;
      acc_r    <= acc_nxt;
      sticky_r <= sticky_nxt;
      i_r      <= i_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_DIMS:       dims_r  <= cfg_wdata[6:0];
          REG_PRIOR_STR:  pstr_r  <= cfg_wdata[15:0];
          REG_PRIOR_MEAN: pmean_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == ST_MUL) begin
      pterm_r <= 64'($signed({1'b0, pstr_r}) * pmean_r);
      den_r   <= 41'(pstr_r) + 41'(tw_r);
    end
    if (state_r == ST_UNUM) begin
      neg_r <= num[63];
    end
    if (out_load) begin
      out_r.result_kind <= (item_r.opcode == OP_SCORE) ? KIND_SCORE : KIND_UPDATE;
      out_r.score       <= (item_r.opcode == OP_SCORE) ? $signed(64'd0 - acc_r) : '0;
      out_r.saturated   <= sticky_r;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CAS_ASSERT(a_div_start_idle, clk, rst_n, div_start |-> !div_busy, "divider restarted while busy")
  `CAS_ASSERT(a_no_rw_clash, clk, rst_n, ctl.re |-> !(ctl.mean_we || ctl.sum_we), "read and write in one cycle")
  `CAS_ASSERT(a_out_load_free, clk, rst_n, out_load |-> (!out_valid_r || !out_stall), "result register overwritten")

endmodule

### hw/rtl/cas_mem.sv
`timescale 1ns / 1ps
// Mean and sum stores: one shared address, registered read, per-entry valid bits.
// Depends on cas_pkg.
module cas_mem import cas_pkg::*; #(
  parameter int DEPTH = MAX_DIMS_DEF,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cas_mem_ctl_t       ctl,
  input  logic [AW-1:0]      addr,
  input  logic signed [31:0] mean_wd,
  input  logic signed [63:0] sum_wd,
  output logic signed [31:0] mean_rd,
  output logic signed [63:0] sum_rd
);

  logic signed [31:0] mean_mem [DEPTH];
  logic signed [63:0] sum_mem  [DEPTH];
  logic [DEPTH-1:0]   mean_vld_r;
  logic [DEPTH-1:0]   sum_vld_r;
  logic signed [31:0] mean_q_r;
  logic signed [63:0] sum_q_r;
  logic               mean_qv_r;
  logic               sum_qv_r;

  always_ff @(posedge clk) begin
    if (ctl.mean_we) begin
      mean_mem[addr] <= mean_wd;
    end
    if (ctl.sum_we) begin
      sum_mem[addr] <= sum_wd;
    end
    if (ctl.re) begin
      mean_q_r <= mean_mem[addr];
      sum_q_r  <= sum_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_vld_r <= '0;
      sum_vld_r  <= '0;
      mean_qv_r  <= 1'b0;
      sum_qv_r   <= 1'b0;
    end else begin
      if (ctl.mean_we) begin
        mean_vld_r[addr] <= 1'b1;
      end
      if (ctl.sum_clr) begin
        sum_vld_r <= '0;
      end else if (ctl.sum_we) begin
        sum_vld_r[addr] <= 1'b1;
      end
      if (ctl.re) begin
        mean_qv_r <= mean_vld_r[addr];
        sum_qv_r  <= sum_vld_r[addr];
      end
    end
  end

  assign mean_rd = mean_qv_r ? mean_q_r : '0;
  assign sum_rd  = sum_qv_r  ? sum_q_r  : '0;

endmodule

### hw/rtl/cas_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on cas_pkg.
module cas_div import cas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [40:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quot
);

  logic [41:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [40:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [41:0] shifted;

  always_comb begin
    shifted  = {rem_r[40:0], quo_r[63]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

### dv/cas_checker.sv
`timescale 1ns / 1ps
// Checker for the centroid accumulate and score block: predicts each result from
// accepted items and register writes, and compares it with the result channel.
// Depends on cas_pkg.
module cas_checker import cas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  cas_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  cas_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam longint unsigned WEIGHT_CAP = (64'd1 << 40) - 64'd1;
  localparam longint unsigned DIST_CAP   = 64'd1 << 63;
  localparam longint          S64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint          S64_MIN    = 64'sh8000_0000_0000_0000;

  longint unsigned dims_cfg, strength_cfg;
  longint          prior_cfg;
  longint          centre [64];
  longint          weighted_sum [64];
  longint unsigned weight_total, dist_sq;
  bit              sat_flag;
  cas_out_t        expected_results [$];

  assign pending = expected_results.size();

  function automatic longint add_clamped(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) begin
      sat_flag = 1;
      return S64_MAX;
    end
    if (b < 0 && a < S64_MIN - b) begin
      sat_flag = 1;
      return S64_MIN;
    end
    return a + b;
  endfunction

  function automatic longint unsigned dims_active();
    return (dims_cfg > 64) ? 64 : dims_cfg;
  endfunction

  task automatic recompute_centres();
    longint unsigned den, mag, q;
    longint          prior_term, num;
    bit              neg;
    den = strength_cfg + weight_total;
    prior_term = longint'(strength_cfg) * prior_cfg;
    if (den == 0) return;
    for (int i = 0; i < dims_active(); i++) begin
      num = add_clamped(weighted_sum[i], prior_term);
      neg = num < 0;
      mag = neg ? (64'd0 - longint'(num)) : num;
      q = mag / den;
      if (neg) begin
        if (q > 64'h8000_0000) begin
          q = 64'h8000_0000;
          sat_flag = 1;
        end
        centre[i] = -longint'(q);
      end else begin
        if (q > 64'h7FFF_FFFF) begin
          q = 64'h7FFF_FFFF;
          sat_flag = 1;
        end
        centre[i] = longint'(q);
      end
    end
  endtask

  task automatic predict_item(cas_in_t it);
    bit              ok;
    longint          d, v;
    longint unsigned m, sq;
    cas_out_t        r;
    ok = it.dim_index < dims_active();
    v = longint'(it.value);
    case (it.opcode)
      OP_LOAD: begin
        if (ok) begin
          centre[it.dim_index] = v;
          weighted_sum[it.dim_index] = 0;
        end
        if (it.last_element) weight_total = 0;
      end
      OP_ADD: begin
        if (ok) weighted_sum[it.dim_index] =
            add_clamped(weighted_sum[it.dim_index], longint'({48'd0, it.weight}) * v);
        if (it.last_element) begin
          weight_total += it.weight;
          if (weight_total > WEIGHT_CAP) begin
            weight_total = WEIGHT_CAP;
            sat_flag = 1;
          end
        end
      end
      OP_SCORE: begin
        if (ok) begin
          d = centre[it.dim_index] - v;
          m = (d < 0) ? -d : d;
          sq = m * m;
          if (sq > DIST_CAP - dist_sq) begin
            dist_sq = DIST_CAP;
            sat_flag = 1;
          end else begin
            dist_sq += sq;
          end
        end
        if (it.last_element) begin
          r.result_kind = KIND_SCORE;
          r.score = 64'd0 - dist_sq;
          r.saturated = sat_flag;
          expected_results.push_back(r);
          dist_sq = 0;
        end
      end
      OP_UPDATE: begin
        recompute_centres();
        r.result_kind = KIND_UPDATE;
        r.score = 0;
        r.saturated = sat_flag;
        expected_results.push_back(r);
      end
      OP_RESET: begin
        foreach (weighted_sum[i]) weighted_sum[i] = 0;
        weight_total = 0;
        sat_flag = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cas_out_t e;
    if (!rst_n) begin
      dims_cfg = 64;
      strength_cfg = 256;
      prior_cfg = 0;
      foreach (centre[i]) begin
        centre[i] = 0;
        weighted_sum[i] = 0;
      end
      weight_total = 0;
      dist_sq = 0;
      sat_flag = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DIMS:       dims_cfg = cfg_wdata[6:0];
          REG_PRIOR_STR:  strength_cfg = cfg_wdata[15:0];
          REG_PRIOR_MEAN: prior_cfg = longint'(signed'(cfg_wdata));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result kind=%0d score=%0d sat=%0d", $realtime,
                     out_data.result_kind, out_data.score, out_data.saturated);
        end else begin
          e = expected_results.pop_front();
          if (out_data !== e) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp kind=%0d score=%0d sat=%0d, got %0d %0d %0d",
                       $realtime, e.result_kind, e.score, e.saturated,
                       out_data.result_kind, out_data.score, out_data.saturated);
          end
        end
      end
      if (in_valid && !in_stall) predict_item(in_data);
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the centroid accumulate and score testbench: clock, reset, stimulus and verdict.
// Depends on cas_pkg, the block and cas_checker.
module tb_top;
  import cas_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  cas_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  cas_out_t    out_data;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = REG_DIMS;
  logic [31:0] cfg_wdata = 0;
  int          fail_count, pending;

  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_requests = 0, holds_done = 0, hold_left = 0;
  int vec_len = 4, sent = 0, vectors = 0;

  always #1 clk = ~clk;

  centroid_accumulate_and_score_top DUT (.*);

  cas_checker u_checker (.*);

  always @(negedge clk) begin
    if (hold_requests != holds_done) begin
      holds_done = hold_requests;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send(input logic [2:0] op, input int idx, input logic [31:0] val,
                      input logic [15:0] w, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{opcode: op, dim_index: idx[5:0], value: val, weight: w, last_element: last};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(32'h3_FFFF) - 32'h2_0000;
    endcase
  endfunction

  task automatic random_items(input int count);
    int target;
    logic [2:0] op;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(99) < 12) begin
        send(3'($urandom_range(7)), $urandom_range(63), $urandom, 16'($urandom),
             1'($urandom_range(1)));
      end else if ($urandom_range(99) < 5) begin
        send(OP_UPDATE, $urandom_range(63), $urandom, 16'($urandom),
             1'($urandom_range(1)));
      end else begin
        case ($urandom_range(9))
          0, 1:    op = OP_LOAD;
          2, 3, 4: op = OP_ADD;
          9:       op = OP_RESET;
          default: op = OP_SCORE;
        endcase
        for (int i = 0; i < vec_len; i++)
          send(op, i, pick_value(), $urandom_range(1) ? 16'd256 : 16'($urandom),
               i == vec_len - 1);
        vectors++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, every opcode, zero denominator, out-of-range element
    write_reg(REG_DIMS, 4);
    write_reg(REG_PRIOR_STR, 0);
    write_reg(REG_PRIOR_MEAN, 32'h8000_0000);
    send(OP_RESET, 0, 0, 0, 0);
    send(OP_UPDATE, 0, 0, 0, 1);
    send(OP_LOAD, 0, 32'h7FFF_FFFF, 0, 0);
    send(OP_LOAD, 1, 32'h8000_0000, 0, 0);
    send(OP_LOAD, 2, 0, 0, 0);
    send(OP_LOAD, 63, 32'h1234_5678, 0, 1);
    send(OP_SCORE, 0, 32'h8000_0000, 0, 0);
    send(OP_SCORE, 1, 32'h7FFF_FFFF, 0, 0);
    send(OP_SCORE, 63, 32'h7FFF_FFFF, 0, 1);
    send(OP_ADD, 0, 32'h7FFF_FFFF, 16'hFFFF, 0);
    send(OP_ADD, 1, 32'h8000_0000, 16'hFFFF, 0);
    send(OP_ADD, 2, 32'hFFFF_FFFF, 16'd0, 0);
    send(OP_ADD, 3, 32'h0001_0000, 16'd256, 1);
    send(OP_UPDATE, 0, 0, 0, 0);
    send(OP_SCORE, 2, 32'h0000_0001, 0, 1);
    send(3'd5, 1, $urandom, 16'($urandom), 1);
    send(3'd6, 2, $urandom, 16'($urandom), 1);
    send(3'd7, 3, $urandom, 16'($urandom), 0);
    send(OP_RESET, 0, 0, 0, 1);
    send(OP_SCORE, 0, 0, 0, 1);
    drain();

    send_idle_pct = 11;
    recv_idle_pct = 51;
    vec_len = 4;
    random_items(140);
    drain();

    write_reg(REG_DIMS, 1);
    write_reg(REG_PRIOR_STR, 16'hFFFF);
    write_reg(REG_PRIOR_MEAN, 32'h7FFF_FFFF);
    send_idle_pct = 51;
    recv_idle_pct = 11;
    vec_len = 1;
    random_items(70);
    // hold off sending until every result is in
    drain();
    write_reg(REG_DIMS, 0);
    vec_len = 3;
    random_items(20);
    drain();
    write_reg(REG_DIMS, 7);
    write_reg(REG_PRIOR_STR, 16'd256);
    write_reg(REG_PRIOR_MEAN, pick_value());
    vec_len = 7;
    random_items(60);
    drain();

    write_reg(REG_DIMS, 127);
    write_reg(REG_PRIOR_STR, $urandom_range(16'hFFFF));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    vec_len = 64;
    hold_requests++;
    // back-to-back results while the receiver holds off, so the input stalls
    send(OP_SCORE, 0, pick_value(), 0, 1);
    send(OP_SCORE, 1, pick_value(), 0, 1);
    send(OP_SCORE, 2, pick_value(), 0, 1);
    random_items(130);
    in_valid <= 0;
    @(negedge clk);

    fork
      begin
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
      end
      begin
        repeat (100000) @(negedge clk);
        $display("timeout waiting for results, %0d outstanding", pending);
      end
    join_any
    disable fork;

    $display("Run covered %0d items in %0d vectors over dimension counts 0 to 127,", sent,
             vectors);
    $display("prior strength and prior mean at both extremes, with both sides stalling.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
